// File: rtl/olid_pkg.sv
// ----------------------------------------------------------------------------
// olid_pkg
// Shared types, codes and helpers of the ordered list block.
// ----------------------------------------------------------------------------
package olid_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_DELETE  = 2'd1,
    ACT_EXTRACT = 2'd2,
    ACT_READ    = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_RD,
    S_SCAN,
    S_EMIT,
    S_DONE
  } state_e;

  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 6;
  localparam int unsigned SizeW = 6;

  // 2**32 mod 9, the residue a negative word carries when read as unsigned
  localparam logic [3:0] NegRem = 4'd4;

  // nonzero and divisible by nine; 64 = 1 mod 9, so 6-bit digits sum to the residue
  function automatic logic is_ninefold(input logic [DataW-1:0] v);
    logic [8:0] s1;
    logic [6:0] s2;
    logic [3:0] target;
    s1 = 9'(v[5:0]) + 9'(v[11:6]) + 9'(v[17:12]) + 9'(v[23:18])
       + 9'(v[29:24]) + 9'(v[31:30]);
    s2 = 7'(s1[5:0]) + 7'(s1[8:6]);
    if (s2 >= 7'd36) s2 = s2 - 7'd36;
    if (s2 >= 7'd18) s2 = s2 - 7'd18;
    if (s2 >= 7'd9)  s2 = s2 - 7'd9;
    target = v[31] ? NegRem : 4'd0;
    return (v != '0) && (s2[3:0] == target);
  endfunction

endpackage

// File: rtl/olid_in_if.sv
// ----------------------------------------------------------------------------
// olid_in_if
// Operation channel of the ordered list block.
// ----------------------------------------------------------------------------
interface olid_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [1:0]                               action;
  logic [olid_pkg::PosW-1:0]                position;
  logic signed [olid_pkg::DataW-1:0]        item_value;

  modport source (output valid, action, position, item_value, input ready);
  modport sink   (input valid, action, position, item_value, output ready);
endinterface

// File: rtl/olid_out_if.sv
// ----------------------------------------------------------------------------
// olid_out_if
// Result channel of the ordered list block.
// ----------------------------------------------------------------------------
interface olid_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [olid_pkg::DataW-1:0]        result_value;
  logic [1:0]                               status;
  logic [olid_pkg::SizeW-1:0]               list_size;
  logic [olid_pkg::SizeW-1:0]               extracted_count;
  logic                                     last;

  modport source (output valid, result_value, status, list_size, extracted_count, last,
                  input ready);
  modport sink   (input valid, result_value, status, list_size, extracted_count, last,
                  output ready);
endinterface

// File: rtl/olid_ram.sv
// ----------------------------------------------------------------------------
// olid_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module olid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ordered_list_insert_delete_extract.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_extract
// Ordered list of signed words in one RAM with insert, delete, extract of
// nonzero multiples of nine, and read.
// ----------------------------------------------------------------------------
//  port    dir  fields                                                  handshake
//  req_i   in   action, position, item_value                            valid/ready
//  rsp_o   out  result_value, status, list_size, extracted_count, last  valid/ready
//
//  one operation at a time; the RAM port moves one word per cycle while no stall holds it
//  insert moves the words from pos on one slot up, delete moves the words above pos one
//  slot down, read fetches one word; full, bad index or empty goes straight to the result
//  extract counts the multiples in a first pass, then emits and compacts in a second
//  reset clears the state, count, dv, rem and output valid only; list words are never read before written
//  a stalled result port holds the extract pass at the next multiple
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_extract #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  olid_in_if.sink    req_i,
  olid_out_if.source rsp_o
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > olid_pkg::PosW) ? CW : olid_pkg::PosW;
  localparam int unsigned DW   = olid_pkg::DataW;
  localparam int unsigned SW   = olid_pkg::SizeW;

  olid_pkg::state_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [DW-1:0] val_q, val_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          dv_q, dv_d;
  logic [AW-1:0] rda_q, rda_d;
  logic [AW-1:0] kept_q, kept_d;
  logic [CW-1:0] found_q, found_d;
  logic [CW-1:0] emit_q, emit_d;
  logic [DW-1:0] res_val_q, res_val_d;
  olid_pkg::status_e res_st_q, res_st_d;

  logic          o_vld_q;
  logic [DW-1:0] o_val_q;
  logic [1:0]    o_st_q;
  logic [SW-1:0] o_size_q;
  logic [SW-1:0] o_cnt_q;
  logic          o_last_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  logic              out_load;
  logic              out_free;
  logic [DW-1:0]     ld_val;
  olid_pkg::status_e ld_st;
  logic [CW-1:0]     ld_cnt;
  logic              ld_last;

  logic          rd_mult;
  logic          stall;
  logic [CMPW-1:0] pos_w, cnt_w;
  logic [CW-1:0]   p_cl;

  olid_ram #(
    .WIDTH(DW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign req_i.ready = (state_q == olid_pkg::S_IDLE);
  assign out_free    = !o_vld_q || rsp_o.ready;
  assign rd_mult     = olid_pkg::is_ninefold(ram_rdata);
  assign pos_w       = CMPW'(req_i.position);
  assign cnt_w       = CMPW'(cnt_q);
  assign p_cl        = (pos_w > cnt_w) ? cnt_q : CW'(req_i.position);
  assign stall       = dv_q && rd_mult && !out_free;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    val_d     = val_q;
    rd_ptr_d  = rd_ptr_q;
    rem_d     = rem_q;
    dv_d      = dv_q;
    rda_d     = rda_q;
    kept_d    = kept_q;
    found_d   = found_q;
    emit_d    = emit_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = rd_ptr_q;
    out_load  = 1'b0;
    ld_val    = res_val_q;
    ld_st     = res_st_q;
    ld_cnt    = '0;
    ld_last   = 1'b1;

    unique case (state_q)
      olid_pkg::S_IDLE: begin
        if (req_i.valid) begin
          res_val_d = '0;
          unique case (olid_pkg::act_e'(req_i.action))
            olid_pkg::ACT_INSERT: begin
              if (cnt_q == CW'(CAPACITY)) begin
                res_st_d = olid_pkg::ST_FULL;
                state_d  = olid_pkg::S_DONE;
              end else begin
                pos_d    = p_cl;
                val_d    = req_i.item_value;
                rem_d    = cnt_q - p_cl;
                rd_ptr_d = AW'(cnt_q - CW'(1));
                dv_d     = 1'b0;
                state_d  = olid_pkg::S_INS;
              end
            end
            olid_pkg::ACT_DELETE: begin
              if (pos_w >= cnt_w) begin
                res_st_d = olid_pkg::ST_RANGE;
                state_d  = olid_pkg::S_DONE;
              end else begin
                rem_d    = cnt_q - CW'(1) - CW'(req_i.position);
                rd_ptr_d = AW'(req_i.position) + AW'(1);
                dv_d     = 1'b0;
                state_d  = olid_pkg::S_DEL;
              end
            end
            olid_pkg::ACT_EXTRACT: begin
              if (cnt_q == '0) begin
                res_st_d = olid_pkg::ST_NONE;
                state_d  = olid_pkg::S_DONE;
              end else begin
                rd_ptr_d = '0;
                rem_d    = cnt_q;
                found_d  = '0;
                dv_d     = 1'b0;
                state_d  = olid_pkg::S_SCAN;
              end
            end
            olid_pkg::ACT_READ: begin
              if (pos_w >= cnt_w) begin
                res_st_d = olid_pkg::ST_RANGE;
                state_d  = olid_pkg::S_DONE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(req_i.position);
                state_d   = olid_pkg::S_RD;
              end
            end
          endcase
        end
      end

      olid_pkg::S_INS: begin
        // walk down, each word moves one slot up
        if (dv_q) begin
          ram_we    = 1'b1;
          ram_waddr = rda_q + AW'(1);
        end
        if (rem_q != '0) begin
          ram_re   = 1'b1;
          rda_d    = rd_ptr_q;
          rd_ptr_d = rd_ptr_q - AW'(1);
          rem_d    = rem_q - CW'(1);
          dv_d     = 1'b1;
        end else begin
          dv_d = 1'b0;
        end
        if (rem_q == '0 && !dv_q) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(pos_q);
          ram_wdata = val_q;
          cnt_d     = cnt_q + CW'(1);
          res_st_d  = olid_pkg::ST_OK;
          state_d   = olid_pkg::S_DONE;
        end
      end

      olid_pkg::S_DEL: begin
        // walk up, each word moves one slot down
        if (dv_q) begin
          ram_we    = 1'b1;
          ram_waddr = rda_q - AW'(1);
        end
        if (rem_q != '0) begin
          ram_re   = 1'b1;
          rda_d    = rd_ptr_q;
          rd_ptr_d = rd_ptr_q + AW'(1);
          rem_d    = rem_q - CW'(1);
          dv_d     = 1'b1;
        end else begin
          dv_d = 1'b0;
        end
        if (rem_q == '0 && !dv_q) begin
          cnt_d    = cnt_q - CW'(1);
          res_st_d = olid_pkg::ST_OK;
          state_d  = olid_pkg::S_DONE;
        end
      end

      olid_pkg::S_RD: begin
        res_val_d = ram_rdata;
        res_st_d  = olid_pkg::ST_OK;
        state_d   = olid_pkg::S_DONE;
      end

      olid_pkg::S_SCAN: begin
        if (dv_q && rd_mult) begin
          found_d = found_q + CW'(1);
        end
        if (rem_q != '0) begin
          ram_re   = 1'b1;
          rd_ptr_d = rd_ptr_q + AW'(1);
          rem_d    = rem_q - CW'(1);
          dv_d     = 1'b1;
        end else begin
          dv_d = 1'b0;
        end
        if (rem_q == '0 && !dv_q) begin
          if (found_q == '0) begin
            res_st_d = olid_pkg::ST_NONE;
            state_d  = olid_pkg::S_DONE;
          end else begin
            // size after compaction is known before the first word goes out
            cnt_d    = cnt_q - found_q;
            rd_ptr_d = '0;
            rem_d    = cnt_q;
            kept_d   = '0;
            emit_d   = '0;
            state_d  = olid_pkg::S_EMIT;
          end
        end
      end

      olid_pkg::S_EMIT: begin
        if (!stall) begin
          if (dv_q) begin
            if (rd_mult) begin
              out_load = 1'b1;
              ld_val   = ram_rdata;
              ld_st    = olid_pkg::ST_OK;
              ld_cnt   = emit_q + CW'(1);
              ld_last  = ((emit_q + CW'(1)) == found_q);
              emit_d   = emit_q + CW'(1);
            end else begin
              ram_we    = 1'b1;
              ram_waddr = kept_q;
              kept_d    = kept_q + AW'(1);
            end
          end
          if (rem_q != '0) begin
            ram_re   = 1'b1;
            rd_ptr_d = rd_ptr_q + AW'(1);
            rem_d    = rem_q - CW'(1);
            dv_d     = 1'b1;
          end else begin
            dv_d = 1'b0;
          end
        end
        if (rem_q == '0 && !dv_q) begin
          state_d = olid_pkg::S_IDLE;
        end
      end

      olid_pkg::S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = olid_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = olid_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olid_pkg::S_IDLE;
      cnt_q   <= '0;
      dv_q    <= 1'b0;
      rem_q   <= '0;
      o_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      dv_q    <= dv_d;
      rem_q   <= rem_d;
      if (out_load) begin
        o_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        o_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    val_q     <= val_d;
    rd_ptr_q  <= rd_ptr_d;
    rda_q     <= rda_d;
    kept_q    <= kept_d;
    found_q   <= found_d;
    emit_q    <= emit_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      o_val_q  <= ld_val;
      o_st_q   <= ld_st;
      o_size_q <= SW'(cnt_d);
      o_cnt_q  <= SW'(ld_cnt);
      o_last_q <= ld_last;
    end
  end

  assign rsp_o.valid           = o_vld_q;
  assign rsp_o.result_value    = o_val_q;
  assign rsp_o.status          = o_st_q;
  assign rsp_o.list_size       = o_size_q;
  assign rsp_o.extracted_count = o_cnt_q;
  assign rsp_o.last            = o_last_q;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the ordered list block: a short table of directed operations, a fill
// to capacity with overflow, then a random mix of insert, delete, extract and
// read. Result words are compared against a local model of the list or a typed table row.
// ----------------------------------------------------------------------------
module testbench;
  import olid_pkg::*;

  localparam int unsigned LIST_DEPTH = 32;
  localparam int unsigned MIX_OPS    = 200;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    status_e                 status;
    logic [SizeW-1:0]        size;
    logic [SizeW-1:0]        count;
    logic                    last;
  } list_rsp_t;

  typedef struct {
    act_e                    act;
    logic [PosW-1:0]         pos;
    logic signed [DataW-1:0] val;
    bit                      typed;
    list_rsp_t               rsp;
  } plan_row_t;

  localparam list_rsp_t NO_TYPED = '{32'sd0, ST_OK, 6'd0, 6'd0, 1'b0};

  logic clk_i;
  logic rst_ni;

  olid_in_if  req_if ();
  olid_out_if rsp_if ();

  ordered_list_insert_delete_extract #(
    .CAPACITY(LIST_DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // local copy of the list
  logic signed [DataW-1:0] list_mem [LIST_DEPTH];
  int unsigned             list_cnt;

  list_rsp_t rsp_backlog [$];
  list_rsp_t fresh_rsp [$];
  int        mismatches;
  int        burst_left;
  bit        sender_steady;

  // directed table; typed results only where obvious
  plan_row_t plan [25] = '{
    '{ACT_READ,    6'd0,  32'sd0,           1'b1, '{32'sd0, ST_RANGE, 6'd0, 6'd0, 1'b1}},
    '{ACT_DELETE,  6'd0,  32'sd0,           1'b1, '{32'sd0, ST_RANGE, 6'd0, 6'd0, 1'b1}},
    '{ACT_EXTRACT, 6'd0,  32'sd0,           1'b1, '{32'sd0, ST_NONE,  6'd0, 6'd0, 1'b1}},
    '{ACT_INSERT,  6'd63, 32'sh7FFF_FFFF,   1'b1, '{32'sd0, ST_OK,    6'd1, 6'd0, 1'b1}},
    '{ACT_INSERT,  6'd0,  32'sh8000_0000,   1'b1, '{32'sd0, ST_OK,    6'd2, 6'd0, 1'b1}},
    '{ACT_INSERT,  6'd1,  -32'sd9,          1'b0, NO_TYPED},
    '{ACT_INSERT,  6'd3,  32'sd18,          1'b0, NO_TYPED},
    '{ACT_INSERT,  6'd0,  32'sd0,           1'b0, NO_TYPED},
    '{ACT_INSERT,  6'd40, 32'sd2147483646,  1'b0, NO_TYPED},
    '{ACT_INSERT,  6'd2,  -32'sd2147483646, 1'b0, NO_TYPED},
    '{ACT_INSERT,  6'd1,  32'sd27,          1'b0, NO_TYPED},
    '{ACT_INSERT,  6'd0,  -32'sd1,          1'b0, NO_TYPED},
    '{ACT_READ,    6'd0,  32'sd0,           1'b0, NO_TYPED},
    '{ACT_READ,    6'd7,  32'sd0,           1'b0, NO_TYPED},
    '{ACT_READ,    6'd8,  32'sd0,           1'b0, NO_TYPED},
    '{ACT_READ,    6'd63, 32'sd0,           1'b0, NO_TYPED},
    '{ACT_DELETE,  6'd8,  32'sd0,           1'b0, NO_TYPED},
    '{ACT_DELETE,  6'd63, 32'sd0,           1'b0, NO_TYPED},
    '{ACT_DELETE,  6'd7,  32'sd0,           1'b0, NO_TYPED},
    '{ACT_DELETE,  6'd0,  32'sd0,           1'b0, NO_TYPED},
    '{ACT_EXTRACT, 6'd0,  32'sd0,           1'b0, NO_TYPED},
    '{ACT_EXTRACT, 6'd5,  32'sd0,           1'b0, NO_TYPED},
    '{ACT_READ,    6'd0,  32'sd0,           1'b0, NO_TYPED},
    '{ACT_INSERT,  6'd1,  32'sd36,          1'b0, NO_TYPED},
    '{ACT_EXTRACT, 6'd0,  32'sd0,           1'b0, NO_TYPED}
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // apply one operation to the local list, results land in fresh_rsp
  function automatic void list_apply(input act_e act, input logic [PosW-1:0] pos,
                                     input logic signed [DataW-1:0] val);
    int unsigned             p;
    int unsigned             i;
    int unsigned             kept;
    int                      w;
    logic signed [DataW-1:0] hits [$];
    fresh_rsp.delete();
    case (act)
      ACT_INSERT: begin
        if (list_cnt >= LIST_DEPTH) begin
          fresh_rsp.push_back('{32'sd0, ST_FULL, SizeW'(list_cnt), 6'd0, 1'b1});
        end else begin
          p = (pos > list_cnt) ? list_cnt : pos;
          for (i = list_cnt; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = val;
          list_cnt++;
          fresh_rsp.push_back('{32'sd0, ST_OK, SizeW'(list_cnt), 6'd0, 1'b1});
        end
      end
      ACT_DELETE: begin
        if (pos >= list_cnt) begin
          fresh_rsp.push_back('{32'sd0, ST_RANGE, SizeW'(list_cnt), 6'd0, 1'b1});
        end else begin
          for (i = pos; i + 1 < list_cnt; i++) list_mem[i] = list_mem[i+1];
          list_cnt--;
          fresh_rsp.push_back('{32'sd0, ST_OK, SizeW'(list_cnt), 6'd0, 1'b1});
        end
      end
      ACT_READ: begin
        if (pos >= list_cnt)
          fresh_rsp.push_back('{32'sd0, ST_RANGE, SizeW'(list_cnt), 6'd0, 1'b1});
        else
          fresh_rsp.push_back('{list_mem[pos], ST_OK, SizeW'(list_cnt), 6'd0, 1'b1});
      end
      default: begin
        kept = 0;
        for (i = 0; i < list_cnt; i++) begin
          w = list_mem[i];
          // zero is never a multiple; negative multiples count
          if (w != 0 && (w % 9) == 0) begin
            hits.push_back(list_mem[i]);
          end else begin
            list_mem[kept] = list_mem[i];
            kept++;
          end
        end
        list_cnt = kept;
        if (hits.size() == 0) begin
          fresh_rsp.push_back('{32'sd0, ST_NONE, SizeW'(list_cnt), 6'd0, 1'b1});
        end else begin
          foreach (hits[k])
            fresh_rsp.push_back('{hits[k], ST_OK, SizeW'(list_cnt), SizeW'(k + 1),
                                  (k + 1 == hits.size())});
        end
      end
    endcase
  endfunction

  function automatic logic signed [DataW-1:0] pick_value();
    int unsigned             k;
    logic signed [DataW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1: begin
        k = $urandom_range(1, 238609294);
        v = DataW'(k * 9);
        if ($urandom_range(0, 1)) v = -v;
      end
      2: begin
        v = DataW'($urandom_range(1, 20) * 9);
        if ($urandom_range(0, 1)) v = -v;
      end
      3: v = '0;
      4: begin
        case ($urandom_range(0, 3))
          0:       v = 32'sh7FFF_FFFF;
          1:       v = 32'sh8000_0000;
          2:       v = -32'sd1;
          default: v = 32'sd2147483646;
        endcase
      end
      5: v = DataW'($urandom_range(0, 200)) - 32'sd100;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic logic [PosW-1:0] pick_pos(input act_e act);
    if ($urandom_range(0, 6) == 0 || list_cnt == 0) return PosW'($urandom_range(0, 63));
    if (act == ACT_INSERT) return PosW'($urandom_range(0, list_cnt));
    return PosW'($urandom_range(0, list_cnt - 1));
  endfunction

  // hand one word to the block, with bursts and gaps on the sender side
  task automatic issue(input act_e act, input logic [PosW-1:0] pos,
                       input logic signed [DataW-1:0] val, input bit typed,
                       input list_rsp_t typed_rsp);
    int gap;
    if (burst_left == 0) begin
      gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.position   <= pos;
    req_if.item_value <= val;
    do @(posedge clk_i); while (!req_if.ready);
    list_apply(act, pos, val);
    if (typed) rsp_backlog.push_back(typed_rsp);
    else foreach (fresh_rsp[k]) rsp_backlog.push_back(fresh_rsp[k]);
  endtask

  // hold the sender until every outstanding result has arrived
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (rsp_backlog.size() != 0);
  endtask

  // receiver stall pattern, switching style as bits 9:8 of ready_cyc step
  int unsigned ready_cyc;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      ready_cyc    <= 0;
    end else begin
      ready_cyc <= ready_cyc + 1;
      case (ready_cyc[9:8])
        2'd0:    rsp_if.ready <= 1'b1;
        2'd1:    rsp_if.ready <= ($urandom_range(0, 3) != 0);
        2'd2:    rsp_if.ready <= ((ready_cyc % 7) < 4);
        default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : watch_rsp
    list_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (rsp_backlog.size() == 0) begin
        $error("result word with nothing expected: value %0d status %0d",
               rsp_if.result_value, rsp_if.status);
        mismatches++;
      end else begin
        want = rsp_backlog.pop_front();
        if (rsp_if.result_value !== want.value) begin
          $error("result_value expected %0d got %0d", want.value, rsp_if.result_value);
          mismatches++;
        end
        if (rsp_if.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, rsp_if.status);
          mismatches++;
        end
        if (rsp_if.list_size !== want.size) begin
          $error("list_size expected %0d got %0d", want.size, rsp_if.list_size);
          mismatches++;
        end
        if (rsp_if.extracted_count !== want.count) begin
          $error("extracted_count expected %0d got %0d", want.count, rsp_if.extracted_count);
          mismatches++;
        end
        if (rsp_if.last !== want.last) begin
          $error("last expected %0d got %0d", want.last, rsp_if.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    act_e act;
    int   r;
    bit   going_up;
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.action     <= ACT_INSERT;
    req_if.position   <= '0;
    req_if.item_value <= '0;
    list_cnt      = 0;
    mismatches    = 0;
    burst_left    = 0;
    sender_steady = 1'b0;
    going_up      = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[n]) issue(plan[n].act, plan[n].pos, plan[n].val, plan[n].typed, plan[n].rsp);

    // fill to capacity, then push into the full list
    while (list_cnt < LIST_DEPTH)
      issue(ACT_INSERT, pick_pos(ACT_INSERT), pick_value(), 1'b0, NO_TYPED);
    repeat (3) issue(ACT_INSERT, pick_pos(ACT_INSERT), pick_value(), 1'b0, NO_TYPED);
    issue(ACT_READ, PosW'(LIST_DEPTH - 1), '0, 1'b0, NO_TYPED);
    issue(ACT_EXTRACT, '0, '0, 1'b0, NO_TYPED);
    drain();

    for (int n = 0; n < MIX_OPS; n++) begin
      sender_steady = (n >= 60 && n < 100);
      if (list_cnt >= LIST_DEPTH) going_up = 1'b0;
      else if (list_cnt <= 2) going_up = 1'b1;
      r = $urandom_range(0, 99);
      if (going_up)
        act = (r < 65) ? ACT_INSERT : (r < 75) ? ACT_DELETE : (r < 90) ? ACT_READ : ACT_EXTRACT;
      else
        act = (r < 15) ? ACT_INSERT : (r < 70) ? ACT_DELETE : (r < 85) ? ACT_READ : ACT_EXTRACT;
      issue(act, pick_pos(act), pick_value(), 1'b0, NO_TYPED);
    end
    drain();
    // longest operation is a full-list extract
    repeat (4 * LIST_DEPTH) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: ordered_list_insert_delete_extract.f
rtl/olid_pkg.sv
rtl/olid_in_if.sv
rtl/olid_out_if.sv
rtl/olid_ram.sv
rtl/ordered_list_insert_delete_extract.sv
dv/testbench.sv
